/* rtl/core/cmcp_pkg.sv */
// Package for the cyclic minimum cost path unit.
// Holds the field widths, the register index codes and the cell record type.
// No dependencies.
package cmcp_pkg;

  localparam int COST_W     = 30;
  localparam int SUM_W      = 48;
  localparam int CNT_W      = 11;
  localparam int BUDGET_W   = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_MAX_COLS = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET    = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             last_col;
    logic             last_cell;
    logic [SUM_W-1:0] sum;
  } cell_sum_t;

endpackage

/* rtl/core/cmcp_cost_if.sv */
// Channel that carries one cell cost per item into the unit.
// Depends on cmcp_pkg.
interface cmcp_cost_if import cmcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cell_cost;

  modport source (output valid, output cell_cost, input ready);
  modport sink (input valid, input cell_cost, output ready);
endinterface

/* rtl/core/cmcp_result_if.sv */
// Channel that carries one result item per matrix out of the unit.
// Depends on cmcp_pkg.
interface cmcp_result_if import cmcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] min_cost;
  logic             within_budget;

  modport source (output valid, output min_cost, output within_budget, input ready);
  modport sink (input valid, input min_cost, input within_budget, output ready);
endinterface

/* rtl/core/cyclic_min_cost_path_unit.sv */
// Top level of the cyclic minimum cost path unit: configuration registers and
// the two stages. Depends on cmcp_pkg, the channel interfaces and the stages.
//
//   channel     dir  payload                     handshake
//   cost_in     in   cell_cost[29:0]             valid/ready
//   result_out  out  min_cost[47:0], within_bud  valid/ready
//   cfg         in   cfg_index[1:0], cfg_data    cfg_we, no wait
//
// One cell is accepted per cycle unless the input stalls; the previous column
// is read one row ahead from the bank RAM, so the single read port sets the rate.
// A result reaches the output register via the cell sum and pending result registers.
// Reset and any write of row_count or col_count restart the matrix at cell (0,0).
// The input stalls only when a finished result and a pending result both wait.
module cyclic_min_cost_path_unit import cmcp_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cmcp_cost_if.sink             cost_in,
  cmcp_result_if.source         result_out
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int KW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [RW-1:0]       rows_m1, rows_m1_next;
  logic [KW-1:0]       cols_m1, cols_m1_next;
  logic [BUDGET_W-1:0] budget;
  logic [CNT_W-1:0]    cnt_v;
  logic                restart, take;
  cell_sum_t           cell_sum;

  assign cnt_v   = cfg_data[CNT_W-1:0];
  assign restart = cfg_we && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT);

  always_comb begin
    if (cnt_v == '0) begin
      rows_m1_next = '0;
    end else if (32'(cnt_v) > 32'(MAX_ROWS)) begin
      rows_m1_next = RW'(MAX_ROWS - 1);
    end else begin
      rows_m1_next = RW'(cnt_v - CNT_W'(1));
    end
    if (cnt_v == '0) begin
      cols_m1_next = '0;
    end else if (32'(cnt_v) > 32'(MAX_COLS)) begin
      cols_m1_next = KW'(MAX_COLS - 1);
    end else begin
      cols_m1_next = KW'(cnt_v - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m1 <= '0;
      cols_m1 <= '0;
      budget  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: rows_m1 <= rows_m1_next;
        REG_COL_COUNT: cols_m1 <= cols_m1_next;
        REG_BUDGET:    budget  <= cfg_data[BUDGET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cmcp_path_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .KW       (KW)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .rows_m1  (rows_m1),
    .cols_m1  (cols_m1),
    .cost_in  (cost_in),
    .cell_sum (cell_sum),
    .take     (take)
  );

  cmcp_result_stage u_result (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .budget     (budget),
    .cell_sum   (cell_sum),
    .take       (take),
    .result_out (result_out)
  );

endmodule

/* rtl/core/cmcp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cmcp_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/cmcp_path_core.sv */
// Path sum stage: sliding three-row window over the previous column, ping-pong
// column banks in two RAMs, saturating sum per cell. Depends on cmcp_pkg,
// cmcp_cost_if and cmcp_ram.
module cmcp_path_core import cmcp_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int KW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic [RW-1:0]     rows_m1,
  input  logic [KW-1:0]     cols_m1,
  cmcp_cost_if.sink         cost_in,
  output cell_sum_t         cell_sum,
  input  logic              take
);

  logic [RW-1:0]    row_idx, row_idx_next;
  logic [KW-1:0]    col_idx, col_idx_next;
  logic             bank, bank_next;
  logic [SUM_W-1:0] win_up, win_mid, prev_first, col_first;
  logic [SUM_W-1:0] rdata0, rdata1, rd_prev;
  logic [SUM_W-1:0] down, m1, best, sum, first_of_col;
  logic [SUM_W:0]   ext;
  logic [RW-1:0]    raddr;
  logic             acc, row_last, col_last;

  assign acc            = cost_in.valid && cost_in.ready;
  assign cost_in.ready  = !cell_sum.valid || take;
  assign row_last       = (row_idx == rows_m1);
  assign col_last       = (col_idx == cols_m1);
  assign rd_prev        = bank ? rdata1 : rdata0;

  always_comb begin
    if (row_last) begin
      down = prev_first;
    end else if (row_idx == '0 && rows_m1 == RW'(1)) begin
      down = win_up;
    end else begin
      down = rd_prev;
    end
    m1   = (win_up < win_mid) ? win_up : win_mid;
    best = (m1 < down) ? m1 : down;
    ext  = {1'b0, best} + {{(SUM_W + 1 - COST_W){1'b0}}, cost_in.cell_cost};
    if (col_idx == '0) begin
      sum = {{(SUM_W - COST_W){1'b0}}, cost_in.cell_cost};
    end else if (ext[SUM_W]) begin
      sum = '1;
    end else begin
      sum = ext[SUM_W-1:0];
    end
    first_of_col = (row_idx == '0) ? sum : col_first;
  end

  always_comb begin
    row_idx_next = row_idx;
    col_idx_next = col_idx;
    bank_next    = bank;
    if (restart) begin
      row_idx_next = '0;
      col_idx_next = '0;
      bank_next    = 1'b0;
    end else if (acc) begin
      if (row_last) begin
        row_idx_next = '0;
        if (col_last) begin
          col_idx_next = '0;
          bank_next    = 1'b0;
        end else begin
          col_idx_next = col_idx + KW'(1);
          bank_next    = ~bank;
        end
      end else begin
        row_idx_next = row_idx + RW'(1);
      end
    end
    if (row_idx_next < rows_m1) begin
      raddr = row_idx_next + RW'(1);
    end else begin
      raddr = '0;
    end
  end

  cmcp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ROWS), .ADDR_W(RW)) u_bank0 (
    .clk   (clk),
    .we    (acc && bank),
    .waddr (row_idx),
    .wdata (sum),
    .raddr (raddr),
    .rdata (rdata0)
  );

  cmcp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ROWS), .ADDR_W(RW)) u_bank1 (
    .clk   (clk),
    .we    (acc && !bank),
    .waddr (row_idx),
    .wdata (sum),
    .raddr (raddr),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx <= '0;
      col_idx <= '0;
      bank    <= 1'b0;
    end else begin
      row_idx <= row_idx_next;
      col_idx <= col_idx_next;
      bank    <= bank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (row_idx == '0) begin
        col_first <= sum;
      end
      if (row_last) begin
        win_up     <= sum;
        win_mid    <= first_of_col;
        prev_first <= first_of_col;
      end else begin
        win_up  <= win_mid;
        win_mid <= down;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_sum.valid <= 1'b0;
    end else if (acc) begin
      cell_sum.valid <= 1'b1;
    end else if (take) begin
      cell_sum.valid <= 1'b0;
    end
    if (acc) begin
      cell_sum.sum       <= sum;
      cell_sum.last_col  <= col_last;
      cell_sum.last_cell <= col_last && row_last;
    end
  end

endmodule

/* rtl/core/cmcp_result_stage.sv */
// Result stage: running minimum over the last column, pending result register
// and output register with the budget compare. Depends on cmcp_pkg, cmcp_result_if.
module cmcp_result_stage import cmcp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic [BUDGET_W-1:0] budget,
  input  cell_sum_t           cell_sum,
  output logic                take,
  cmcp_result_if.source       result_out
);

  logic [SUM_W-1:0] run_min, r_min, cand;
  logic             rv, o_valid, out_load;

  assign out_load         = !o_valid || result_out.ready;
  assign take             = cell_sum.valid && (!cell_sum.last_cell || !rv || out_load);
  assign cand             = (cell_sum.sum < run_min) ? cell_sum.sum : run_min;
  assign result_out.valid = o_valid;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      run_min <= '1;
    end else if (take && cell_sum.last_col) begin
      run_min <= cell_sum.last_cell ? '1 : cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (take && cell_sum.last_cell) begin
      rv <= 1'b1;
    end else if (out_load) begin
      rv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cell_sum.last_cell) begin
      r_min <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_out.min_cost      <= r_min;
      result_out.within_budget <= (r_min <= {{(SUM_W - BUDGET_W){1'b0}}, budget});
    end
  end

endmodule

/* test/tb.sv */
// Testbench for cyclic_min_cost_path_unit: streams matrices of cell costs and checks each
// minimum path result against a predictor kept in step with every accepted item.
// Depends on cmcp_pkg, cmcp_cost_if, cmcp_result_if and the unit itself.
module tb;
  import cmcp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SUM_W-1:0] min_cost;
    logic             within_budget;
  } path_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cmcp_cost_if cost_ch ();
  cmcp_result_if result_ch ();

  cyclic_min_cost_path_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cost_in(cost_ch),
    .result_out(result_ch)
  );

  always #1 clk = ~clk;

  logic [COST_W-1:0] pending_cells[$];
  path_result_t expected_paths[$];
  logic cost_taken = 1'b0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned stim_items = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // Predictor state.
  logic [SUM_W-1:0] col_sums[2][DEF_MAX_ROWS];
  bit bank_sel;
  int unsigned row_pos;
  int unsigned col_pos;
  logic [SUM_W-1:0] best_total;
  logic [CNT_W-1:0] rows_reg;
  logic [CNT_W-1:0] cols_reg;
  logic [BUDGET_W-1:0] budget_reg;

  function automatic int unsigned eff_count(logic [CNT_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void restart_path();
    bank_sel = 1'b0;
    row_pos = 0;
    col_pos = 0;
    best_total = '1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ROW_COUNT: begin
        rows_reg = data[CNT_W-1:0];
        restart_path();
      end
      REG_COL_COUNT: begin
        cols_reg = data[CNT_W-1:0];
        restart_path();
      end
      REG_BUDGET: budget_reg = data[BUDGET_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void path_step(logic [COST_W-1:0] cost);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned up;
    int unsigned down;
    logic [SUM_W-1:0] least;
    logic [SUM_W:0] total;
    path_result_t done;
    rows = eff_count(rows_reg, DEF_MAX_ROWS);
    cols = eff_count(cols_reg, DEF_MAX_COLS);
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    if (col_pos == 0) begin
      total = {{(SUM_W + 1 - COST_W){1'b0}}, cost};
    end else begin
      up = (r == 0) ? rows - 1 : r - 1;
      down = (r + 1 >= rows) ? 0 : r + 1;
      least = col_sums[bank_sel][up];
      if (col_sums[bank_sel][r] < least) least = col_sums[bank_sel][r];
      if (col_sums[bank_sel][down] < least) least = col_sums[bank_sel][down];
      total = {1'b0, least} + cost;
      if (total[SUM_W]) total = {1'b0, {SUM_W{1'b1}}};
    end
    col_sums[~bank_sel][r] = total[SUM_W-1:0];
    if (col_pos + 1 >= cols && total[SUM_W-1:0] < best_total) best_total = total[SUM_W-1:0];
    if (r + 1 >= rows) begin
      if (col_pos + 1 >= cols) begin
        done.min_cost = best_total;
        done.within_budget = (best_total <= budget_reg);
        expected_paths.push_back(done);
        restart_path();
      end else begin
        row_pos = 0;
        col_pos++;
        bank_sel = ~bank_sel;
      end
    end else begin
      row_pos = r + 1;
    end
  endfunction

  task automatic report_mismatch(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
    $display("cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Acceptance, prediction and checking all happen at the rising edge.
  always @(posedge clk) begin
    path_result_t want;
    if (rst) begin
      cost_taken <= 1'b0;
      rows_reg = 1;
      cols_reg = 1;
      budget_reg = '0;
      restart_path();
    end else begin
      cost_taken <= cost_ch.valid && cost_ch.ready;
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (cost_ch.valid && cost_ch.ready) path_step(cost_ch.cell_cost);
      if (result_ch.valid && result_ch.ready) begin
        if (expected_paths.size() == 0) begin
          report_mismatch("result with nothing expected", result_ch.min_cost, '0);
        end else begin
          want = expected_paths.pop_front();
          if (result_ch.min_cost !== want.min_cost)
            report_mismatch("min_cost", result_ch.min_cost, want.min_cost);
          if (result_ch.within_budget !== want.within_budget)
            report_mismatch("within_budget", result_ch.within_budget, want.within_budget);
        end
      end
    end
  end

  always @(negedge clk) begin
    logic send;
    if (rst) begin
      cost_ch.valid <= 1'b0;
    end else begin
      if (cost_taken) void'(pending_cells.pop_front());
      if (!cost_ch.valid || cost_taken) begin
        send = pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct;
        cost_ch.valid <= send;
        if (send) cost_ch.cell_cost <= pending_cells[0];
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Long receiver hold-off, counted down here.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left <= hold_request;
      hold_request = 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void push_cell(logic [COST_W-1:0] cost);
    pending_cells.push_back(cost);
    stim_items++;
  endfunction

  function automatic logic [COST_W-1:0] random_cost();
    case ($urandom_range(9))
      0: return COST_W'($urandom());
      1: return COST_W'($urandom_range(0, 1000000000));
      2: return ($urandom_range(1) != 0) ? COST_MAX : '0;
      default: return COST_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic void push_matrix(int unsigned cells);
    repeat (cells) push_cell(random_cost());
  endfunction

  function automatic logic [CFG_DATA_W-1:0] count_word(logic [CNT_W-1:0] v);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'({$urandom(), $urandom()});
    if ($urandom_range(1) != 0) w = '0;
    w[CNT_W-1:0] = v;
    return w;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sizes(logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] c);
    write_reg(REG_ROW_COUNT, r);
    write_reg(REG_COL_COUNT, c);
  endtask

  // Configuration is only touched once the unit has drained.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_cells.size() != 0 || expected_paths.size() != 0 || cost_ch.valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned phase_paths;
    int unsigned pick;
    int unsigned cells;
    int unsigned part;
    logic [CNT_W-1:0] rows_raw;
    logic [CNT_W-1:0] cols_raw;
    int unsigned cur_rows;
    int unsigned cur_cols;
    logic [CFG_DATA_W-1:0] budget_word;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ROW_COUNT;
    cfg_data = '0;
    cost_ch.valid = 1'b0;
    cost_ch.cell_cost = '0;
    result_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset sizes are one by one, reset budget is zero.
    push_cell('0);
    push_cell(COST_MAX);
    wait_idle();
    write_reg(REG_UNUSED, '1);
    push_cell(7);
    wait_idle();

    set_sizes(3, 3);
    write_reg(REG_BUDGET, 15);
    push_cell(5); push_cell(1); push_cell(9);
    push_cell(2); push_cell(8); push_cell(3);
    push_cell(7); push_cell(4); push_cell(6);
    wait_idle();

    // A count write in the middle of a matrix drops the partial matrix.
    set_sizes(4, 2);
    push_matrix(3);
    wait_idle();
    write_reg(REG_COL_COUNT, 2);
    push_matrix(8);
    wait_idle();

    // A budget write in the middle of a matrix applies to its result.
    push_matrix(4);
    wait_idle();
    write_reg(REG_BUDGET, 1500);
    push_matrix(4);
    wait_idle();

    set_sizes(0, 0);
    push_cell(12);
    wait_idle();
    set_sizes(40'hFF_FFFF_F802, 40'hAA_AAAA_A803);
    push_matrix(6);
    wait_idle();
    write_reg(REG_BUDGET, '1);
    repeat (6) push_cell(COST_MAX);
    wait_idle();

    // Receiver holds off while single-cell matrices keep coming.
    set_sizes(1, 1);
    write_reg(REG_BUDGET, 500);
    hold_request = 300;
    repeat (40) push_cell(random_cost());
    wait_idle();

    cur_rows = 1;
    cur_cols = 1;
    rows_raw = 1;
    cols_raw = 1;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct = 14;
          recv_stall_pct = 14;
        end
      endcase
      phase_start = stim_items;
      phase_paths = 0;
      while (stim_items - phase_start < 150 || phase_paths < 12) begin
        pick = $urandom_range(99);
        cells = cur_rows * cur_cols;
        if (pick < 20) begin
          wait_idle();
          rows_raw = CNT_W'(($urandom_range(9) == 0) ? $urandom_range(0, 32)
                                                     : $urandom_range(1, 6));
          cols_raw = CNT_W'(($urandom_range(9) == 0) ? $urandom_range(0, 32)
                                                     : $urandom_range(1, 6));
          cur_rows = (rows_raw == 0) ? 1 : rows_raw;
          cur_cols = (cols_raw == 0) ? 1 : cols_raw;
          set_sizes(count_word(rows_raw), count_word(cols_raw));
          case ($urandom_range(3))
            0: budget_word = '0;
            1: budget_word = CFG_DATA_W'({$urandom(), $urandom()});
            2: budget_word = cur_cols * $urandom_range(0, 1000);
            default: budget_word = $urandom_range(0, cur_cols * 700);
          endcase
          write_reg(REG_BUDGET, budget_word);
        end else if (pick < 26 && cells > 1) begin
          push_matrix($urandom_range(1, cells - 1));
          wait_idle();
          if ($urandom_range(1) != 0) write_reg(REG_ROW_COUNT, count_word(rows_raw));
          else write_reg(REG_COL_COUNT, count_word(cols_raw));
        end else if (pick < 32 && cells > 1) begin
          part = $urandom_range(1, cells - 1);
          push_matrix(part);
          wait_idle();
          write_reg(REG_BUDGET, $urandom_range(0, cur_cols * 700));
          push_matrix(cells - part);
          phase_paths++;
        end else begin
          push_matrix(cells);
          phase_paths++;
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
